// File: hdl/assert_macros.svh
// Assertion macros used by the RTL of the link controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Check on every clock edge, reset included.
`define ASSERT_ALL(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALL(lbl, prop, msg)
`endif
`endif

// File: hdl/hdlc_pkg.sv
// Types, codes and sizes of the half-duplex link controller.
package hdlc_pkg;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_TX   = 2'd1,
      MODE_RX   = 2'd2,
      MODE_STOP = 2'd3
   } mode_type;

   localparam logic [3:0] CMD_ENQ     = 4'd0;
   localparam logic [3:0] CMD_OUT_RDY = 4'd1;
   localparam logic [3:0] CMD_ACK     = 4'd2;
   localparam logic [3:0] CMD_NAK     = 4'd3;
   localparam logic [3:0] CMD_TIMEOUT = 4'd4;
   localparam logic [3:0] CMD_GOOD    = 4'd5;
   localparam logic [3:0] CMD_BAD     = 4'd6;
   localparam logic [3:0] CMD_EOT     = 4'd7;
   localparam logic [3:0] CMD_END     = 4'd8;

   localparam logic [2:0] ACT_NONE   = 3'd0;
   localparam logic [2:0] ACT_ENQ    = 3'd1;
   localparam logic [2:0] ACT_ACK    = 3'd2;
   localparam logic [2:0] ACT_NAK    = 3'd3;
   localparam logic [2:0] ACT_NEXT   = 3'd4;
   localparam logic [2:0] ACT_RESEND = 3'd5;
   localparam logic [2:0] ACT_EOT    = 3'd6;
   localparam logic [2:0] ACT_CLEAR  = 3'd7;

   localparam logic [2:0] ST_BUSY       = 3'd0;
   localparam logic [2:0] ST_TX_DONE    = 3'd1;
   localparam logic [2:0] ST_TX_FAIL    = 3'd2;
   localparam logic [2:0] ST_RX_DONE    = 3'd3;
   localparam logic [2:0] ST_RX_TIMEOUT = 3'd4;
   localparam logic [2:0] ST_STOPPED    = 3'd5;
   localparam logic [2:0] ST_BACKOFF    = 3'd6;

   localparam logic [7:0] FRAME_LIMIT_RESET = 8'd10;
   localparam logic [7:0] FRAME_LIMIT_MIN   = 8'd2;
   localparam logic [7:0] COUNT_MAX         = 8'd255;

   localparam logic [1:0] REG_FRAME_LIMIT = 2'd0;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [3:0] cmd;
      logic       queue_empty;
   } req_type;

   typedef struct packed {
      logic [2:0] action;
      logic [2:0] status;
      logic       last;
   } rsp_type;

endpackage

// File: hdl/half_duplex_link_controller.sv
// Half-duplex ENQ/ACK stop-and-wait link controller, top level.
//
// Usage: each req_ beat carries one link event (cmd, queue_empty). The block
// updates its link mode, frame count and retry count in the cycle the beat
// is accepted and pushes one or two action beats (action, status, last)
// into a four-entry result queue that drives the rsp_ channel. last marks
// the final result beat of an event.
// Result beats are registered in the result queue before they reach rsp_.
// One event per cycle while each event yields one result beat and the
// receiver takes each beat; an event yielding two result beats occupies the
// result channel for both, so the sustained rate is one result beat per
// cycle, set by the single read port of the result queue.
// req_ready is high while the queue has room for two beats, so a stalled
// receiver holds the event channel off after at most three further events;
// nothing is dropped.
// The frame limit is written through the APB port at address 0 (reset 10).
// Reset (synchronous, active high) returns the link to idle, clears the
// counters and empties the result queue. An end event stops the link until
// the next reset.
`include "assert_macros.svh"

module half_duplex_link_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hdlc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hdlc_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   hdlc_pkg::mode_type mode_ff, mode_in;
   logic [7:0] frame_limit_ff;
   logic [7:0] frames_ff, frames_in;
   logic [7:0] retry_ff, retry_in;
   logic       enq_acked_ff, enq_acked_in;

   hdlc_pkg::rsp_type         queue_ff [hdlc_pkg::QUEUE_DEPTH];
   logic [hdlc_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [hdlc_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [hdlc_pkg::QCNT_W-1:0] count_ff, count_in;

   logic       accept, pop;
   logic [7:0] limit, frames_inc, retry_inc;
   logic       tx_full, retry_out;
   logic [1:0] push_n;
   hdlc_pkg::rsp_type res0, res1;
   logic       reg_sel;
   logic       q_bound, stopped, link_clear, turn_start, counts_clear;

   // ---------------- configuration port ----------------
   assign pready  = 1'b1;
   assign reg_sel = (paddr[2] == hdlc_pkg::REG_FRAME_LIMIT[0]);
   assign prdata  = reg_sel ? {24'd0, frame_limit_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_limit_ff <= hdlc_pkg::FRAME_LIMIT_RESET;
      end else if (psel && penable && pwrite && pready && reg_sel) begin
         frame_limit_ff <= pwdata[7:0];
      end
   end

   // ---------------- shared decode ----------------
   assign accept     = req_valid && req_ready;
   assign pop        = rsp_valid && rsp_ready;
   assign req_ready  = (count_ff <= hdlc_pkg::QCNT_W'(hdlc_pkg::QUEUE_DEPTH - 2));
   assign limit      = (frame_limit_ff < hdlc_pkg::FRAME_LIMIT_MIN) ?
                       hdlc_pkg::FRAME_LIMIT_MIN : frame_limit_ff;
   // saturate the counters at their top value
   assign frames_inc = (frames_ff == hdlc_pkg::COUNT_MAX) ? frames_ff : frames_ff + 8'd1;
   assign retry_inc  = (retry_ff == hdlc_pkg::COUNT_MAX) ? retry_ff : retry_ff + 8'd1;
   assign tx_full    = (frames_inc >= limit);
   assign retry_out  = (retry_inc >= (limit - 8'd1));

   // ---------------- next state ----------------
   always_comb begin
      mode_in      = mode_ff;
      frames_in    = frames_ff;
      retry_in     = retry_ff;
      enq_acked_in = enq_acked_ff;
      if (accept && (mode_ff != hdlc_pkg::MODE_STOP)) begin
         if (req_data.cmd == hdlc_pkg::CMD_END) begin
            mode_in = hdlc_pkg::MODE_STOP;
         end else begin
            unique case (mode_ff)
               hdlc_pkg::MODE_IDLE: begin
                  if (req_data.cmd == hdlc_pkg::CMD_ENQ) begin
                     mode_in = hdlc_pkg::MODE_RX;
                  end else if (req_data.cmd == hdlc_pkg::CMD_OUT_RDY) begin
                     frames_in    = 8'd0;
                     retry_in     = 8'd0;
                     enq_acked_in = 1'b0;
                     mode_in      = req_data.queue_empty ? hdlc_pkg::MODE_IDLE
                                                         : hdlc_pkg::MODE_TX;
                  end
               end
               hdlc_pkg::MODE_TX: begin
                  if (req_data.cmd == hdlc_pkg::CMD_ENQ) begin
                     mode_in = hdlc_pkg::MODE_IDLE;
                  end else if (req_data.cmd == hdlc_pkg::CMD_ACK) begin
                     enq_acked_in = 1'b1;
                     retry_in     = 8'd0;
                     frames_in    = frames_inc;
                     if (tx_full || req_data.queue_empty) begin
                        mode_in = hdlc_pkg::MODE_IDLE;
                     end
                  end else if (req_data.cmd == hdlc_pkg::CMD_NAK ||
                               req_data.cmd == hdlc_pkg::CMD_TIMEOUT) begin
                     if (!enq_acked_ff) begin
                        mode_in = hdlc_pkg::MODE_IDLE;
                     end else begin
                        retry_in = retry_inc;
                        if (retry_out || req_data.queue_empty) begin
                           mode_in = hdlc_pkg::MODE_IDLE;
                        end
                     end
                  end
               end
               hdlc_pkg::MODE_RX: begin
                  if (req_data.cmd == hdlc_pkg::CMD_EOT ||
                      req_data.cmd == hdlc_pkg::CMD_TIMEOUT) begin
                     mode_in = hdlc_pkg::MODE_IDLE;
                  end
               end
               default: begin
                  mode_in = mode_ff;
               end
            endcase
         end
      end
   end

   // ---------------- result beats ----------------
   always_comb begin
      res0   = '{action: hdlc_pkg::ACT_NONE, status: hdlc_pkg::ST_BUSY, last: 1'b1};
      res1   = '{action: hdlc_pkg::ACT_NONE, status: hdlc_pkg::ST_BUSY, last: 1'b1};
      push_n = 2'd0;
      if (accept) begin
         push_n = 2'd1;
         if (mode_ff == hdlc_pkg::MODE_STOP || req_data.cmd == hdlc_pkg::CMD_END) begin
            res0.status = hdlc_pkg::ST_STOPPED;
         end else begin
            unique case (mode_ff)
               hdlc_pkg::MODE_IDLE: begin
                  if (req_data.cmd == hdlc_pkg::CMD_ENQ) begin
                     res0.action = hdlc_pkg::ACT_ACK;
                  end else if (req_data.cmd == hdlc_pkg::CMD_OUT_RDY) begin
                     res0.action = hdlc_pkg::ACT_ENQ;
                     if (req_data.queue_empty) begin
                        res0.last   = 1'b0;
                        res1.action = hdlc_pkg::ACT_EOT;
                        res1.status = hdlc_pkg::ST_TX_DONE;
                        push_n      = 2'd2;
                     end
                  end
               end
               hdlc_pkg::MODE_TX: begin
                  if (req_data.cmd == hdlc_pkg::CMD_ENQ) begin
                     res0.status = hdlc_pkg::ST_BACKOFF;
                  end else if (req_data.cmd == hdlc_pkg::CMD_ACK) begin
                     res0.action = hdlc_pkg::ACT_NEXT;
                     if (tx_full || req_data.queue_empty) begin
                        res0.last   = 1'b0;
                        res1.action = hdlc_pkg::ACT_EOT;
                        res1.status = hdlc_pkg::ST_TX_DONE;
                        push_n      = 2'd2;
                     end
                  end else if (req_data.cmd == hdlc_pkg::CMD_NAK ||
                               req_data.cmd == hdlc_pkg::CMD_TIMEOUT) begin
                     if (!enq_acked_ff) begin
                        res0.status = hdlc_pkg::ST_TX_DONE;
                     end else begin
                        res0.action = hdlc_pkg::ACT_RESEND;
                        if (retry_out) begin
                           res0.last   = 1'b0;
                           res1.action = hdlc_pkg::ACT_CLEAR;
                           res1.status = hdlc_pkg::ST_TX_FAIL;
                           push_n      = 2'd2;
                        end else if (req_data.queue_empty) begin
                           res0.last   = 1'b0;
                           res1.action = hdlc_pkg::ACT_EOT;
                           res1.status = hdlc_pkg::ST_TX_DONE;
                           push_n      = 2'd2;
                        end
                     end
                  end
               end
               hdlc_pkg::MODE_RX: begin
                  if (req_data.cmd == hdlc_pkg::CMD_GOOD) begin
                     res0.action = hdlc_pkg::ACT_ACK;
                  end else if (req_data.cmd == hdlc_pkg::CMD_BAD) begin
                     res0.action = hdlc_pkg::ACT_NAK;
                  end else if (req_data.cmd == hdlc_pkg::CMD_EOT) begin
                     res0.status = hdlc_pkg::ST_RX_DONE;
                  end else if (req_data.cmd == hdlc_pkg::CMD_TIMEOUT) begin
                     res0.status = hdlc_pkg::ST_RX_TIMEOUT;
                  end
               end
               default: begin
                  res0.status = hdlc_pkg::ST_STOPPED;
               end
            endcase
         end
      end
   end

   // ---------------- result queue ----------------
   assign wr_ptr_in = wr_ptr_ff + hdlc_pkg::QPTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + hdlc_pkg::QPTR_W'(pop);
   assign count_in  = count_ff + hdlc_pkg::QCNT_W'(push_n) - hdlc_pkg::QCNT_W'(pop);
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = queue_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_ff + hdlc_pkg::QPTR_W'(1)] <= res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= hdlc_pkg::MODE_IDLE;
         frames_ff    <= 8'd0;
         retry_ff     <= 8'd0;
         enq_acked_ff <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
      end else begin
         mode_ff      <= mode_in;
         frames_ff    <= frames_in;
         retry_ff     <= retry_in;
         enq_acked_ff <= enq_acked_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
      end
   end

   // ---------------- assertions ----------------
   assign q_bound      = (count_ff <= hdlc_pkg::QCNT_W'(hdlc_pkg::QUEUE_DEPTH));
   assign stopped      = (mode_ff == hdlc_pkg::MODE_STOP);
   assign link_clear   = (count_ff == '0) && (mode_ff == hdlc_pkg::MODE_IDLE);
   assign turn_start   = accept && (mode_ff == hdlc_pkg::MODE_IDLE) &&
                         (req_data.cmd == hdlc_pkg::CMD_OUT_RDY);
   assign counts_clear = (retry_ff == 8'd0) && (frames_ff == 8'd0);

   `ASSERT_CLK(a_queue_bound, q_bound, "result queue overflow")
   `ASSERT_CLK(a_stop_sticky, stopped |=> stopped, "left stopped mode")
   `ASSERT_ALL(a_reset_empty, reset |=> link_clear, "reset did not clear link")
   `ASSERT_CLK(a_retry_zero_idle, turn_start |=> counts_clear, "turn start kept counters")

endmodule

// File: tb/testbench.sv
// Self-checking testbench of the half-duplex ENQ/ACK link controller.
`timescale 1ns / 1ps

module testbench;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   hdlc_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   hdlc_pkg::rsp_type rsp_data;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [2:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   half_duplex_link_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Link controller mirror
   hdlc_pkg::mode_type link_state  = hdlc_pkg::MODE_IDLE;
   logic [7:0]         frames_out  = '0;
   logic [7:0]         resend_cnt  = '0;
   bit                 enq_granted = 1'b0;
   logic [7:0]         limit_reg   = hdlc_pkg::FRAME_LIMIT_RESET;

   hdlc_pkg::req_type pending_events[$];
   hdlc_pkg::rsp_type expected_actions[$];

   int send_idle_pct = 19;
   int recv_idle_pct = 57;
   bit rsp_hold = 1'b0;
   bit req_taken = 1'b0;
   int events_accepted = 0;
   int beats_checked = 0;
   int settings_used = 0;
   int error_count = 0;

   function automatic void predict_actions(hdlc_pkg::req_type ev);
      logic [7:0] lim;
      logic [2:0] a0, s0, a1, s1;
      int         n;
      lim = (limit_reg < hdlc_pkg::FRAME_LIMIT_MIN) ? hdlc_pkg::FRAME_LIMIT_MIN : limit_reg;
      n = 1;
      a0 = hdlc_pkg::ACT_NONE;
      s0 = hdlc_pkg::ST_BUSY;
      a1 = hdlc_pkg::ACT_NONE;
      s1 = hdlc_pkg::ST_BUSY;
      if (link_state == hdlc_pkg::MODE_STOP) begin
         s0 = hdlc_pkg::ST_STOPPED;
      end else if (ev.cmd == hdlc_pkg::CMD_END) begin
         link_state = hdlc_pkg::MODE_STOP;
         s0 = hdlc_pkg::ST_STOPPED;
      end else if (link_state == hdlc_pkg::MODE_IDLE) begin
         if (ev.cmd == hdlc_pkg::CMD_ENQ) begin
            link_state = hdlc_pkg::MODE_RX;
            a0 = hdlc_pkg::ACT_ACK;
         end else if (ev.cmd == hdlc_pkg::CMD_OUT_RDY) begin
            frames_out = '0;
            resend_cnt = '0;
            enq_granted = 1'b0;
            a0 = hdlc_pkg::ACT_ENQ;
            if (ev.queue_empty) begin
               n = 2;
               a1 = hdlc_pkg::ACT_EOT;
               s1 = hdlc_pkg::ST_TX_DONE;
            end else begin
               link_state = hdlc_pkg::MODE_TX;
            end
         end
      end else if (link_state == hdlc_pkg::MODE_TX) begin
         if (ev.cmd == hdlc_pkg::CMD_ENQ) begin
            link_state = hdlc_pkg::MODE_IDLE;
            s0 = hdlc_pkg::ST_BACKOFF;
         end else if (ev.cmd == hdlc_pkg::CMD_ACK) begin
            enq_granted = 1'b1;
            resend_cnt = '0;
            if (frames_out != hdlc_pkg::COUNT_MAX) frames_out = frames_out + 8'd1;
            a0 = hdlc_pkg::ACT_NEXT;
            if (frames_out >= lim || ev.queue_empty) begin
               n = 2;
               a1 = hdlc_pkg::ACT_EOT;
               s1 = hdlc_pkg::ST_TX_DONE;
               link_state = hdlc_pkg::MODE_IDLE;
            end
         end else if (ev.cmd == hdlc_pkg::CMD_NAK || ev.cmd == hdlc_pkg::CMD_TIMEOUT) begin
            if (!enq_granted) begin
               link_state = hdlc_pkg::MODE_IDLE;
               s0 = hdlc_pkg::ST_TX_DONE;
            end else begin
               if (resend_cnt != hdlc_pkg::COUNT_MAX) resend_cnt = resend_cnt + 8'd1;
               a0 = hdlc_pkg::ACT_RESEND;
               if (resend_cnt >= lim - 8'd1) begin
                  n = 2;
                  a1 = hdlc_pkg::ACT_CLEAR;
                  s1 = hdlc_pkg::ST_TX_FAIL;
                  link_state = hdlc_pkg::MODE_IDLE;
               end else if (ev.queue_empty) begin
                  n = 2;
                  a1 = hdlc_pkg::ACT_EOT;
                  s1 = hdlc_pkg::ST_TX_DONE;
                  link_state = hdlc_pkg::MODE_IDLE;
               end
            end
         end
      end else begin
         if (ev.cmd == hdlc_pkg::CMD_GOOD) begin
            a0 = hdlc_pkg::ACT_ACK;
         end else if (ev.cmd == hdlc_pkg::CMD_BAD) begin
            a0 = hdlc_pkg::ACT_NAK;
         end else if (ev.cmd == hdlc_pkg::CMD_EOT) begin
            link_state = hdlc_pkg::MODE_IDLE;
            s0 = hdlc_pkg::ST_RX_DONE;
         end else if (ev.cmd == hdlc_pkg::CMD_TIMEOUT) begin
            link_state = hdlc_pkg::MODE_IDLE;
            s0 = hdlc_pkg::ST_RX_TIMEOUT;
         end
      end
      expected_actions.push_back({a0, s0, n == 1});
      if (n == 2) expected_actions.push_back({a1, s1, 1'b1});
   endfunction

   // Monitor: check result beats, predict on accepted event beats
   always @(posedge clock) begin
      hdlc_pkg::rsp_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_actions.size() == 0) begin
               $error("unexpected result beat: action %0d status %0d last %0d",
                      rsp_data.action, rsp_data.status, rsp_data.last);
               error_count++;
            end else begin
               want = expected_actions.pop_front();
               beats_checked++;
               if (rsp_data.action !== want.action) begin
                  $error("action mismatch: expected %0d, got %0d", want.action, rsp_data.action);
                  error_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status mismatch: expected %0d, got %0d", want.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last mismatch: expected %0d, got %0d", want.last, rsp_data.last);
                  error_count++;
               end
            end
         end
         req_taken = req_valid && req_ready;
         if (req_taken) begin
            predict_actions(req_data);
            events_accepted++;
         end
      end
   end

   // Driver: hold the beat until taken, then advance or idle
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_events.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            req_data  <= pending_events.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !rsp_hold && ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // Long receiver stall so the result queue fills and backs up the event channel
   initial begin
      wait (events_accepted >= 40);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (200) @(posedge clock);
      rsp_hold = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("** half_duplex_link_controller: FAILED **");
      $finish;
   end

   function automatic void add_event(logic [3:0] cmd, bit empty);
      hdlc_pkg::req_type ev;
      ev.cmd = cmd;
      ev.queue_empty = empty;
      pending_events.push_back(ev);
   endfunction

   function automatic logic [3:0] pick_retry();
      return $urandom_range(1, 0) ? hdlc_pkg::CMD_NAK : hdlc_pkg::CMD_TIMEOUT;
   endfunction

   function automatic void queue_tx_turn(int lim);
      int frames, retries;
      add_event(hdlc_pkg::CMD_OUT_RDY, $urandom_range(15, 0) == 0);
      // drop the turn before the ENQ is answered now and then
      if ($urandom_range(7, 0) == 0) begin
         add_event(pick_retry(), 1'($urandom_range(1, 0)));
         return;
      end
      frames = $urandom_range((lim < 10 ? lim : 10) + 1, 1);
      for (int f = 0; f < frames; f++) begin
         if ($urandom_range(11, 0) == 0) begin
            add_event(hdlc_pkg::CMD_ENQ, 1'($urandom_range(1, 0)));
            return;
         end
         retries = 0;
         if (f > 0 && $urandom_range(2, 0) == 0) retries = $urandom_range(lim < 6 ? lim : 6, 1);
         for (int k = 0; k < retries; k++) add_event(pick_retry(), $urandom_range(9, 0) == 0);
         add_event(hdlc_pkg::CMD_ACK, (f == frames - 1) ? ($urandom_range(3, 0) != 0)
                                                        : ($urandom_range(19, 0) == 0));
      end
   endfunction

   function automatic void queue_rx_turn();
      int beats;
      add_event(hdlc_pkg::CMD_ENQ, 1'($urandom_range(1, 0)));
      beats = $urandom_range(8, 1);
      for (int k = 0; k < beats; k++)
         add_event($urandom_range(1, 0) ? hdlc_pkg::CMD_GOOD : hdlc_pkg::CMD_BAD,
                   1'($urandom_range(1, 0)));
      add_event($urandom_range(3, 0) == 0 ? hdlc_pkg::CMD_TIMEOUT : hdlc_pkg::CMD_EOT,
                1'($urandom_range(1, 0)));
   endfunction

   function automatic void queue_noise();
      logic [3:0] cmd;
      cmd = 4'($urandom_range(15, 0));
      // keep the end event out of the random part
      if (cmd == hdlc_pkg::CMD_END) cmd = cmd + 4'd1;
      add_event(cmd, 1'($urandom_range(1, 0)));
   endfunction

   function automatic void queue_random(int target, int lim);
      int added, n0, pick;
      added = 0;
      while (added < target) begin
         n0 = pending_events.size();
         pick = $urandom_range(9, 0);
         if (pick < 5) queue_tx_turn(lim);
         else if (pick < 8) queue_rx_turn();
         else queue_noise();
         added += pending_events.size() - n0;
      end
   endfunction

   task automatic wait_quiet();
      do begin
         @(posedge clock);
      end while (pending_events.size() != 0 || req_valid || expected_actions.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_frame_limit(logic [7:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 3'(4 * hdlc_pkg::REG_FRAME_LIMIT);
      pwdata  <= {24'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      limit_reg = value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== {24'd0, value}) begin
         $error("frame limit readback mismatch: expected %0d, got %0d", value, prdata);
         error_count++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      settings_used++;
   endtask

   initial begin
      logic [7:0] cfg;
      int         eff;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed events at the reset limit
      add_event(hdlc_pkg::CMD_ACK, 1'b1);
      add_event(4'hF, 1'b0);
      add_event(hdlc_pkg::CMD_OUT_RDY, 1'b1);
      add_event(hdlc_pkg::CMD_OUT_RDY, 1'b0);
      add_event(hdlc_pkg::CMD_NAK, 1'b0);
      add_event(hdlc_pkg::CMD_OUT_RDY, 1'b0);
      add_event(hdlc_pkg::CMD_TIMEOUT, 1'b1);
      add_event(hdlc_pkg::CMD_OUT_RDY, 1'b0);
      add_event(hdlc_pkg::CMD_ACK, 1'b0);
      add_event(hdlc_pkg::CMD_NAK, 1'b0);
      add_event(hdlc_pkg::CMD_TIMEOUT, 1'b1);
      add_event(hdlc_pkg::CMD_OUT_RDY, 1'b0);
      add_event(hdlc_pkg::CMD_ACK, 1'b0);
      add_event(hdlc_pkg::CMD_GOOD, 1'b1);
      add_event(hdlc_pkg::CMD_ENQ, 1'b0);
      add_event(hdlc_pkg::CMD_ENQ, 1'b1);
      add_event(hdlc_pkg::CMD_GOOD, 1'b0);
      add_event(hdlc_pkg::CMD_BAD, 1'b1);
      add_event(hdlc_pkg::CMD_ACK, 1'b0);
      add_event(hdlc_pkg::CMD_EOT, 1'b0);
      add_event(hdlc_pkg::CMD_ENQ, 1'b0);
      add_event(hdlc_pkg::CMD_TIMEOUT, 1'b0);

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0:       cfg = 8'd2;
            1:       cfg = 8'($urandom_range(8, 3));
            2:       cfg = hdlc_pkg::COUNT_MAX;
            3:       cfg = 8'd0;
            4:       cfg = 8'($urandom_range(12, 2));
            default: cfg = 8'd1;
         endcase
         wait_quiet();
         write_frame_limit(cfg);
         eff = int'((cfg < hdlc_pkg::FRAME_LIMIT_MIN) ? hdlc_pkg::FRAME_LIMIT_MIN : cfg);
         @(posedge clock);
         send_idle_pct = (ph < 2) ? 19 : (ph < 4) ? 57 : 0;
         recv_idle_pct = (ph < 2) ? 57 : (ph < 4) ? 19 : 0;
         queue_random(75, eff);
      end

      // stop the link, then show it stays stopped
      wait_quiet();
      add_event(hdlc_pkg::CMD_END, 1'b0);
      add_event(hdlc_pkg::CMD_ENQ, 1'b0);
      add_event(hdlc_pkg::CMD_OUT_RDY, 1'b1);
      add_event(4'hC, 1'b1);
      wait_quiet();
      repeat (4) @(negedge clock);

      $display("Ran %0d link events, checked %0d action beats across %0d frame limit settings.",
               events_accepted, beats_checked, settings_used);
      if (error_count == 0) begin
         $display("** half_duplex_link_controller: PASSED **");
      end else begin
         $display("** half_duplex_link_controller: FAILED **");
      end
      $finish;
   end

endmodule
